// ===== hdl/xkb64_pkg.sv =====
// ---------------------------------------------------------------------------
// xkb64_pkg
// Shared types, constants and the base64 alphabet for the XOR/base64 encoder.
// ---------------------------------------------------------------------------
package xkb64_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int KEY_WORDS     = 4;
  localparam int KPOS_W        = $clog2(MAX_KEY_BYTES);
  localparam int KLEN_W        = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;

  localparam logic [6:0] PAD_CHAR = 7'd61;

  // one accepted byte worth of output characters
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;  // index of the last valid slot
    logic            fin;       // message ends with this record
  } rec_t;

  typedef struct packed {
    logic              full;
    logic              empty;
  } qstat_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [KPOS_W-1:0] key_pos;
  } fstat_t;

  function automatic logic [6:0] b64_char(input logic [5:0] code);
    logic [6:0] c;
    c = {1'b0, code};
    if (code < 6'd26)      b64_char = c + 7'd65;
    else if (code < 6'd52) b64_char = c + 7'd71;
    else if (code < 6'd62) b64_char = c - 7'd4;
    else if (code == 6'd62) b64_char = 7'd43;
    else                    b64_char = 7'd47;
  endfunction

endpackage

// ===== hdl/xkb64_front.sv =====
// ---------------------------------------------------------------------------
// xkb64_front
// Config registers, key XOR and 6-bit grouping; builds one record per byte.
// ---------------------------------------------------------------------------
module xkb64_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xkb64_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tlast,
  input  logic                          q_full,
  output logic                          push,
  output xkb64_pkg::rec_t               push_rec,
  output xkb64_pkg::fstat_t             st
);
  import xkb64_pkg::*;

  logic [KLEN_W-1:0]               key_len_r;
  logic [KEY_WORDS-1:0][63:0]      key_r;
  logic [KPOS_W-1:0]               kpos_r, kpos_nxt;
  logic [1:0]                      phase_r, phase_nxt;
  logic [3:0]                      carry_r, carry_nxt;

  logic [KLEN_W-1:0] eff_len;
  logic [KLEN_W-1:0] pos_inc;
  logic [7:0]        key_byte;
  logic [7:0]        b;
  logic [5:0]        c0, c1;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign st        = '{phase: phase_r, key_pos: kpos_r};

  always_comb begin
    if (key_len_r == '0) eff_len = KLEN_W'(1);
    else if (key_len_r > KLEN_W'(MAX_KEY_BYTES)) eff_len = KLEN_W'(MAX_KEY_BYTES);
    else eff_len = key_len_r;
  end

  assign pos_inc  = {1'b0, kpos_r} + KLEN_W'(1);
  assign key_byte = key_r[kpos_r[KPOS_W-1:3]][{kpos_r[2:0], 3'b000} +: 8];
  assign b        = in_tdata ^ key_byte;

  always_comb begin
    c1        = 6'd0;
    push_rec  = '0;
    case (phase_r)
      2'd1: begin
        c0        = {carry_r[1:0], b[7:4]};
        carry_nxt = b[3:0];
        phase_nxt = 2'd2;
        push_rec.last_idx = in_tlast ? 2'd2 : 2'd0;
        c1        = {b[3:0], 2'b00};
      end
      2'd2: begin
        c0        = {carry_r, b[7:6]};
        c1        = b[5:0];
        carry_nxt = 4'd0;
        phase_nxt = 2'd0;
        push_rec.last_idx = 2'd1;
      end
      default: begin
        c0        = b[7:2];
        carry_nxt = {2'b00, b[1:0]};
        phase_nxt = 2'd1;
        push_rec.last_idx = in_tlast ? 2'd3 : 2'd0;
        c1        = {b[1:0], 4'b0000};
      end
    endcase
    push_rec.chars[0] = b64_char(c0);
    push_rec.chars[1] = b64_char(c1);
    push_rec.chars[2] = PAD_CHAR;
    push_rec.chars[3] = PAD_CHAR;
    push_rec.fin      = in_tlast;

    kpos_nxt = (pos_inc >= eff_len) ? '0 : pos_inc[KPOS_W-1:0];
    if (in_tlast) begin
      kpos_nxt  = '0;
      phase_nxt = 2'd0;
      carry_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= KLEN_W'(1);
      key_r     <= '0;
      kpos_r    <= '0;
      phase_r   <= 2'd0;
      carry_r   <= 4'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_LENGTH: key_len_r <= cfg_data[KLEN_W-1:0];
          REG_KEY_WORD_0: key_r[0]  <= cfg_data;
          REG_KEY_WORD_1: key_r[1]  <= cfg_data;
          REG_KEY_WORD_2: key_r[2]  <= cfg_data;
          REG_KEY_WORD_3: key_r[3]  <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        kpos_r  <= kpos_nxt;
        phase_r <= phase_nxt;
        carry_r <= carry_nxt;
      end
    end
  end

endmodule

// ===== hdl/xkb64_queue.sv =====
// ---------------------------------------------------------------------------
// xkb64_queue
// Small FIFO of character records between front and back.
// ---------------------------------------------------------------------------
module xkb64_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xkb64_pkg::rec_t   push_rec,
  input  logic              pop,
  output xkb64_pkg::rec_t   head,
  output xkb64_pkg::qstat_t stat
);
  import xkb64_pkg::*;

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign head       = mem_r[rptr_r];
  assign stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QPTR_W'(1);
      if (pop)  rptr_r <= rptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/xkb64_back.sv =====
// ---------------------------------------------------------------------------
// xkb64_back
// Walks the head record slot by slot into a registered output stage.
// ---------------------------------------------------------------------------
module xkb64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xkb64_pkg::rec_t   head,
  input  xkb64_pkg::qstat_t stat,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import xkb64_pkg::*;

  logic [1:0] idx_r;
  logic       vld_r;
  logic [6:0] char_r;
  logic       last_r;
  logic       load;
  logic       at_end;

  assign load   = !stat.empty && (!vld_r || out_tready);
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && at_end;

  assign out_tvalid = vld_r;
  assign out_tdata  = {1'b0, char_r};
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= head.chars[idx_r];
      last_r <= head.fin && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/xor_key_base64_encoder_top.sv =====
// ---------------------------------------------------------------------------
// xor_key_base64_encoder_top
// Repeating-key XOR of a byte stream followed by base64 encoding.
//
//   channel  dir  payload                               transfer when
//   in_      in   tdata[7:0] message byte, tlast final  in_tvalid & in_tready
//   out_     out  tdata[6:0] ASCII char, tlast final    out_tvalid & out_tready
//   cfg_     in   index 0 length, 1..4 key words        cfg_valid & cfg_ready
//
// Output runs at one character per cycle from a registered stage while out_tready is high;
// that port sets throughput: one or two characters per byte, a final byte up to four.
// Input is taken every cycle while the 4-entry record queue has room.
// A byte's characters pass through the record queue and then the registered output stage.
// rst_n is synchronous; config is always ready and takes effect at once.
// ---------------------------------------------------------------------------
module xor_key_base64_encoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xkb64_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] message_byte
  input  logic                            in_tlast,   // final_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [6:0] text_char, [7] zero
  output logic                            out_tlast   // final_char
);
  import xkb64_pkg::*;

  logic   push, pop;
  rec_t   push_rec, head;
  qstat_t q_stat;
  fstat_t f_stat;

  xkb64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_stat.full),
    .push      (push),
    .push_rec  (push_rec),
    .st        (f_stat)
  );

  xkb64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  xkb64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .stat       (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("push into full queue");

  a_msg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_tlast) |=> (f_stat.phase == 2'd0 && f_stat.key_pos == '0))
    else $error("state not cleared after final byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid right after reset");

endmodule
